// ===== hw/rtl/tha_pkg.sv =====
// Shared constants, types and the arctangent table for the tilt and heading unit.
// Used by every module of the block; depends on nothing.
package tha_pkg;

  // CORDIC depth and output angle format
  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int TAB_LEN         = 24;
  localparam int TAB_BITS        = 20;
  localparam int CORDIC_USED     = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

  // square root: one result bit per cell, 32 result bits
  localparam int SQRT_STEPS = 32;

  // front end is three registers, then sqrt row, prep, CORDIC row, output
  localparam int LATENCY = 3 + SQRT_STEPS + 1 + CORDIC_USED + 1;

  // accel scaling: |v| * 312 / 10, the divide done by reciprocal
  localparam int SCALE_MUL   = 312;
  localparam int RECIP_SHIFT = 27;
  localparam int RECIP       = 13421773;  // ceil(2^27 / 10)

  // datapath widths
  localparam int XW = 36;  // CORDIC x and y
  localparam int AW = 29;  // angle accumulator, degrees * 2^20

  // angle constants in accumulator and output units
  localparam int FULL_ACC  = 90 << TAB_BITS;
  localparam int RND_SH    = TAB_BITS - ANGLE_FRAC_BITS;
  localparam int RND_HALF  = 1 << (RND_SH - 1);
  localparam int DEG90_OUT = 90 << ANGLE_FRAC_BITS;
  localparam int DEG180_OUT = 180 << ANGLE_FRAC_BITS;

  // input selector codes
  localparam logic REQ_ACCEL   = 1'b0;
  localparam logic REQ_COMPASS = 1'b1;

  // per-lane flags for special cases and final sign handling
  typedef struct packed {
    logic zero_num;
    logic zero_den;
    logic neg;
    logic sub180;
    logic bad;
  } lane_ctl_t;

  // square root lane: radicand bits still to bring down, remainder, root
  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_lane_t;

  typedef struct packed {
    logic              vld;
    logic              comp;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [20:0]       vx;
    logic [20:0]       vy;
    logic [20:0]       vz;
    sq_lane_t [2:0]    ln;
  } sq_item_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] a;
    lane_ctl_t            ctl;
  } cd_lane_t;

  typedef struct packed {
    logic           vld;
    logic [20:0]    vx;
    logic [20:0]    vy;
    logic [20:0]    vz;
    cd_lane_t [2:0] ln;
  } cd_item_t;

  // atan(2^-i) in degrees * 2^20, rounded
  function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] i);
    logic signed [AW-1:0] v;
    case (i)
      5'd0:    v = 29'sd47185920;
      5'd1:    v = 29'sd27855475;
      5'd2:    v = 29'sd14718068;
      5'd3:    v = 29'sd7471121;
      5'd4:    v = 29'sd3750058;
      5'd5:    v = 29'sd1876857;
      5'd6:    v = 29'sd938658;
      5'd7:    v = 29'sd469357;
      5'd8:    v = 29'sd234682;
      5'd9:    v = 29'sd117342;
      5'd10:   v = 29'sd58671;
      5'd11:   v = 29'sd29335;
      5'd12:   v = 29'sd14668;
      5'd13:   v = 29'sd7334;
      5'd14:   v = 29'sd3667;
      5'd15:   v = 29'sd1833;
      5'd16:   v = 29'sd917;
      5'd17:   v = 29'sd458;
      5'd18:   v = 29'sd229;
      5'd19:   v = 29'sd115;
      5'd20:   v = 29'sd57;
      5'd21:   v = 29'sd29;
      5'd22:   v = 29'sd14;
      5'd23:   v = 29'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/tha_sqrt_cell.sv =====
// One cell of the square root row: yields one root bit for each of three lanes.
// Depends on tha_pkg.
module tha_sqrt_cell import tha_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  sq_item_t d_in,
  output sq_item_t d_out
);

  sq_item_t nxt;

  // restoring digit step: bring down two radicand bits, try root*4+1
  always_comb begin
    logic [35:0] rsh;
    logic [35:0] trial;
    nxt = d_in;
    for (int k = 0; k < 3; k++) begin
      rsh   = {d_in.ln[k].rem, d_in.ln[k].rad[63:62]};
      trial = {2'b00, d_in.ln[k].root, 2'b01};
      nxt.ln[k].rad = {d_in.ln[k].rad[61:0], 2'b00};
      if (rsh >= trial) begin
        nxt.ln[k].rem  = 34'(rsh - trial);
        nxt.ln[k].root = {d_in.ln[k].root[30:0], 1'b1};
      end else begin
        nxt.ln[k].rem  = rsh[33:0];
        nxt.ln[k].root = {d_in.ln[k].root[30:0], 1'b0};
      end
    end
  end

  // valid flag is reset, payload is not
  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.vld <= 1'b0;
    end else begin
      d_out.vld <= d_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    d_out.comp <= nxt.comp;
    d_out.ax   <= nxt.ax;
    d_out.ay   <= nxt.ay;
    d_out.az   <= nxt.az;
    d_out.vx   <= nxt.vx;
    d_out.vy   <= nxt.vy;
    d_out.vz   <= nxt.vz;
    d_out.ln   <= nxt.ln;
  end

endmodule

// ===== hw/rtl/tha_cordic_cell.sv =====
// One vectoring CORDIC cell: rotates three lanes toward the x axis by atan(2^-idx).
// Depends on tha_pkg.
module tha_cordic_cell import tha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [4:0] idx,
  input  cd_item_t   d_in,
  output cd_item_t   d_out
);

  cd_item_t nxt;

  // rotate by sign of y, accumulate table angle
  always_comb begin
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [AW-1:0] ang;
    nxt = d_in;
    ang = atan_tab(idx);
    for (int k = 0; k < 3; k++) begin
      dx = d_in.ln[k].y >>> idx;
      dy = d_in.ln[k].x >>> idx;
      if (!d_in.ln[k].y[XW-1]) begin
        nxt.ln[k].x = d_in.ln[k].x + dx;
        nxt.ln[k].y = d_in.ln[k].y - dy;
        nxt.ln[k].a = d_in.ln[k].a + ang;
      end else begin
        nxt.ln[k].x = d_in.ln[k].x - dx;
        nxt.ln[k].y = d_in.ln[k].y + dy;
        nxt.ln[k].a = d_in.ln[k].a - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.vld <= 1'b0;
    end else begin
      d_out.vld <= d_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    d_out.vx <= nxt.vx;
    d_out.vy <= nxt.vy;
    d_out.vz <= nxt.vz;
    d_out.ln <= nxt.ln;
  end

endmodule

// ===== hw/rtl/tilt_and_heading_angles.sv =====
// Top level of the tilt and heading angle unit: front end, sqrt row, CORDIC row, output.
// Depends on tha_pkg, tha_sqrt_cell and tha_cordic_cell.
//
// Usage:
//   A sample is transferred in at a clock edge with start high and busy low.
//   busy is never raised: the unit is fully pipelined and takes one sample
//   every cycle, with no state carried from one sample to the next.
//   req_type selects accelerometer (tilt angles, scaled axes) or compass
//   (headings, raw axes); byte_0..byte_5 carry the raw 16-bit axes.
//   Each sample yields one result, shown for one cycle with done high.
//   From the start transfer to done, a sample passes through:
//     3 front-end stages (decode, squares and x312, sums and /10),
//     32 square-root cells (one root bit each), 1 operand prep stage,
//     CORDIC_STAGES CORDIC cells, 1 output stage.
//   Throughput is one result per cycle; every cell of both rows works on a
//   different sample in each cycle.
//   Synchronous reset clears the valid flags of all stages, so samples in
//   flight are dropped and no done follows. The receiver cannot stall: it
//   must take every result in its done cycle.
module tilt_and_heading_angles import tha_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [7:0]         byte_0,
  input  logic [7:0]         byte_1,
  input  logic [7:0]         byte_2,
  input  logic [7:0]         byte_3,
  input  logic [7:0]         byte_4,
  input  logic [7:0]         byte_5,
  output logic               done,
  output logic signed [15:0] angle_first,
  output logic signed [15:0] angle_second,
  output logic signed [15:0] angle_third,
  output logic signed [20:0] value_x,
  output logic signed [20:0] value_y,
  output logic signed [20:0] value_z,
  output logic               invalid
);

  // finish one lane: clamp, round, specials, quadrant, sign, saturate
  function automatic logic signed [15:0] fin_angle(input cd_lane_t l);
    logic signed [31:0] a;
    logic signed [31:0] r;
    a = {{(32 - AW){l.a[AW-1]}}, l.a};
    if (a < 0) a = 0;
    if (a > FULL_ACC) a = FULL_ACC;
    r = (a + RND_HALF) >>> RND_SH;
    if (l.ctl.zero_num) r = 0;
    else if (l.ctl.zero_den) r = DEG90_OUT;
    if (l.ctl.sub180) r = DEG180_OUT - r;
    if (l.ctl.neg) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    return v[15] ? 17'(17'd0 - e) : e;
  endfunction

  assign busy = 1'b0;

  // ---- stage 0: register and decode the sample
  logic               s0_vld;
  logic               s0_comp;
  logic signed [15:0] s0_x, s0_y, s0_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else begin
      s0_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_comp <= req_type;
    if (req_type == REQ_ACCEL) begin
      s0_x <= {byte_1, byte_0};
      s0_y <= {byte_3, byte_2};
      s0_z <= {byte_5, byte_4};
    end else begin
      s0_x <= {byte_0, byte_1};
      s0_z <= {byte_2, byte_3};
      s0_y <= {byte_4, byte_5};
    end
  end

  // ---- stage 1: squares, and |v| * 312
  logic               s1_vld;
  logic               s1_comp;
  logic signed [15:0] s1_x, s1_y, s1_z;
  logic [30:0]        s1_sqx, s1_sqy, s1_sqz;
  logic [25:0]        s1_mx, s1_my, s1_mz;
  logic signed [31:0] p_x, p_y, p_z;

  assign p_x = s0_x * s0_x;
  assign p_y = s0_y * s0_y;
  assign p_z = s0_z * s0_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_comp <= s0_comp;
    s1_x    <= s0_x;
    s1_y    <= s0_y;
    s1_z    <= s0_z;
    s1_sqx  <= p_x[30:0];
    s1_sqy  <= p_y[30:0];
    s1_sqz  <= p_z[30:0];
    s1_mx   <= 26'(abs16(s0_x)) * 26'(SCALE_MUL);
    s1_my   <= 26'(abs16(s0_y)) * 26'(SCALE_MUL);
    s1_mz   <= 26'(abs16(s0_z)) * 26'(SCALE_MUL);
  end

  // ---- stage 2: sums of squares, /10 by reciprocal; feeds the sqrt row
  logic [49:0] q_x, q_y, q_z;
  logic [20:0] sc_x, sc_y, sc_z;
  sq_item_t    sq_chain [SQRT_STEPS+1];

  assign q_x  = (50'(s1_mx) * 50'(RECIP)) >> RECIP_SHIFT;
  assign q_y  = (50'(s1_my) * 50'(RECIP)) >> RECIP_SHIFT;
  assign q_z  = (50'(s1_mz) * 50'(RECIP)) >> RECIP_SHIFT;
  assign sc_x = s1_x[15] ? 21'(21'd0 - q_x[20:0]) : q_x[20:0];
  assign sc_y = s1_y[15] ? 21'(21'd0 - q_y[20:0]) : q_y[20:0];
  assign sc_z = s1_z[15] ? 21'(21'd0 - q_z[20:0]) : q_z[20:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_chain[0].vld <= 1'b0;
    end else begin
      sq_chain[0].vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    sq_chain[0].comp <= s1_comp;
    sq_chain[0].ax   <= s1_x;
    sq_chain[0].ay   <= s1_y;
    sq_chain[0].az   <= s1_z;
    if (s1_comp == REQ_COMPASS) begin
      sq_chain[0].vx <= {{5{s1_x[15]}}, s1_x};
      sq_chain[0].vy <= {{5{s1_y[15]}}, s1_y};
      sq_chain[0].vz <= {{5{s1_z[15]}}, s1_z};
    end else begin
      sq_chain[0].vx <= sc_x;
      sq_chain[0].vy <= sc_y;
      sq_chain[0].vz <= sc_z;
    end
    // lane 0 |yz|, lane 1 |xz|, lane 2 |xy|
    sq_chain[0].ln[0] <= '{rad: {32'(s1_sqy) + 32'(s1_sqz), 32'd0}, rem: '0, root: '0};
    sq_chain[0].ln[1] <= '{rad: {32'(s1_sqx) + 32'(s1_sqz), 32'd0}, rem: '0, root: '0};
    sq_chain[0].ln[2] <= '{rad: {32'(s1_sqx) + 32'(s1_sqy), 32'd0}, rem: '0, root: '0};
  end

  // ---- square root row
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    tha_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .d_in  (sq_chain[g]),
      .d_out (sq_chain[g+1])
    );
  end

  // ---- prep: pick numerator and denominator per lane, set special-case flags
  sq_item_t sq_last;
  cd_item_t cd_chain [CORDIC_USED+1];
  cd_item_t prep;

  assign sq_last = sq_chain[SQRT_STEPS];

  always_comb begin
    logic signed [33:0] n [3];
    logic signed [33:0] d [3];
    logic signed [33:0] ux, uy, uz;
    logic signed [33:0] an, ad;
    ux = {{2{sq_last.ax[15]}}, sq_last.ax, 16'd0};
    uy = {{2{sq_last.ay[15]}}, sq_last.ay, 16'd0};
    uz = {{2{sq_last.az[15]}}, sq_last.az, 16'd0};
    if (sq_last.comp == REQ_COMPASS) begin
      n[0] = uy; d[0] = ux;
      n[1] = uz; d[1] = ux;
      n[2] = uz; d[2] = uy;
    end else begin
      n[0] = ux; d[0] = {2'b00, sq_last.ln[0].root};
      n[1] = uy; d[1] = {2'b00, sq_last.ln[1].root};
      n[2] = {2'b00, sq_last.ln[2].root}; d[2] = uz;
    end
    prep.vld = sq_last.vld;
    prep.vx  = sq_last.vx;
    prep.vy  = sq_last.vy;
    prep.vz  = sq_last.vz;
    for (int k = 0; k < 3; k++) begin
      an = n[k][33] ? -n[k] : n[k];
      ad = d[k][33] ? -d[k] : d[k];
      prep.ln[k].x = XW'(ad);
      prep.ln[k].y = XW'(an);
      prep.ln[k].a = '0;
      prep.ln[k].ctl.zero_num = (n[k] == 0);
      prep.ln[k].ctl.zero_den = (d[k] == 0);
      if (sq_last.comp == REQ_COMPASS) begin
        prep.ln[k].ctl.neg    = n[k][33];
        prep.ln[k].ctl.sub180 = d[k][33];
        prep.ln[k].ctl.bad    = 1'b0;
      end else begin
        prep.ln[k].ctl.neg    = n[k][33] ^ d[k][33];
        prep.ln[k].ctl.sub180 = 1'b0;
        prep.ln[k].ctl.bad    = (n[k] == 0) && (d[k] == 0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cd_chain[0].vld <= 1'b0;
    end else begin
      cd_chain[0].vld <= prep.vld;
    end
  end

  always_ff @(posedge clk) begin
    cd_chain[0].vx <= prep.vx;
    cd_chain[0].vy <= prep.vy;
    cd_chain[0].vz <= prep.vz;
    cd_chain[0].ln <= prep.ln;
  end

  // ---- CORDIC row
  for (genvar g = 0; g < CORDIC_USED; g++) begin : g_cordic
    tha_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .idx   (5'(g)),
      .d_in  (cd_chain[g]),
      .d_out (cd_chain[g+1])
    );
  end

  // ---- output register
  cd_item_t cd_last;
  assign cd_last = cd_chain[CORDIC_USED];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cd_last.vld;
    end
  end

  always_ff @(posedge clk) begin
    angle_first  <= fin_angle(cd_last.ln[0]);
    angle_second <= fin_angle(cd_last.ln[1]);
    angle_third  <= fin_angle(cd_last.ln[2]);
    value_x      <= cd_last.vx;
    value_y      <= cd_last.vy;
    value_z      <= cd_last.vz;
    invalid      <= cd_last.ln[0].ctl.bad | cd_last.ln[1].ctl.bad | cd_last.ln[2].ctl.bad;
  end

endmodule

// ===== hw/rtl/tha_checker.sv =====
// Port-level checks for the tilt and heading angle unit, bound to its top level.
// Depends on tha_pkg and tilt_and_heading_angles.
module tha_checker import tha_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               req_type,
  input logic               done,
  input logic signed [15:0] angle_first,
  input logic signed [15:0] angle_second,
  input logic signed [15:0] angle_third,
  input logic               invalid
);

  // every transfer in gives a result after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("no result after accepted sample");

  // no result without a transfer in at the matching cycle
  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching sample");

  // invalid only comes from accelerometer samples
  a_inv_accel: assert property (@(posedge clk) disable iff (rst)
    (done && invalid) |-> ($past(req_type, LATENCY) == REQ_ACCEL))
    else $error("invalid flag on compass sample");

  // a zero over zero tilt reads as an angle of zero
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (done && invalid) |-> (angle_first == 0 || angle_second == 0 || angle_third == 0))
    else $error("invalid flag without a zero angle");

endmodule

bind tilt_and_heading_angles tha_checker u_tha_checker (.*);

// ===== tb/tb_tilt_and_heading_angles.sv =====
// Self-checking testbench for tilt_and_heading_angles: accelerometer tilt and compass heading.
// Depends on tha_pkg and the tilt_and_heading_angles RTL; predicts every result in-line.
`timescale 1ns / 100ps

module tb_tilt_and_heading_angles;
  import tha_pkg::*;

  typedef struct {
    logic       kind;
    logic [7:0] b [6];
  } sample_t;

  typedef struct {
    logic signed [15:0] ang [3];
    logic signed [20:0] val [3];
    logic               inv;
  } angles_t;

  localparam longint CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic req_type = 1'b0;
  logic [7:0] byte_0 = '0, byte_1 = '0, byte_2 = '0, byte_3 = '0, byte_4 = '0, byte_5 = '0;
  logic done;
  logic signed [15:0] angle_first, angle_second, angle_third;
  logic signed [20:0] value_x, value_y, value_z;
  logic invalid;

  sample_t pending_q [$];
  angles_t expected_q [$];
  int      errors = 0;
  longint  cycles = 0;
  bit      stim_done = 1'b0;
  int      burst_left = 0;
  int      gap_left = 0;

  tilt_and_heading_angles i_dut (
    .clk, .rst, .start, .busy, .req_type,
    .byte_0, .byte_1, .byte_2, .byte_3, .byte_4, .byte_5,
    .done, .angle_first, .angle_second, .angle_third,
    .value_x, .value_y, .value_z, .invalid
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // atan table, degrees * 2^20
  function automatic longint atan_step(int i);
    longint t [24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
                       469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
                       917, 458, 229, 115, 57, 29, 14, 7};
    return t[i];
  endfunction

  function automatic longint root_floor(logic [63:0] v);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v -= r + bt;
        r = (r >> 1) + bt;
      end else r >>= 1;
      bt >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint magnitude(longint a, longint b);
    logic [63:0] s;
    s = a * a + b * b;
    return root_floor(s << 32);
  endfunction

  // first-quadrant arctangent via vectoring CORDIC, output units
  function automatic longint atan_first_quad(longint n, longint d);
    longint x, y, a, dx, dy;
    x = d;
    y = n;
    a = 0;
    if (n == 0) return 0;
    if (d == 0) return 90 << ANGLE_FRAC_BITS;
    for (int i = 0; i < CORDIC_USED; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; a += atan_step(i);
      end else begin
        x -= dx; y += dy; a -= atan_step(i);
      end
    end
    if (a < 0) a = 0;
    if (a > (longint'(90) << TAB_BITS)) a = longint'(90) << TAB_BITS;
    return (a + (longint'(1) << (TAB_BITS - ANGLE_FRAC_BITS - 1))) >>> (TAB_BITS - ANGLE_FRAC_BITS);
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint tilt_angle(longint n, longint d, ref logic bad);
    longint r;
    if (n == 0 && d == 0) begin
      bad = 1'b1;
      return 0;
    end
    if (d == 0) return n < 0 ? -(90 << ANGLE_FRAC_BITS) : (90 << ANGLE_FRAC_BITS);
    r = atan_first_quad(labs(n), labs(d));
    return ((n < 0) != (d < 0)) ? -r : r;
  endfunction

  function automatic longint heading_angle(longint n, longint d);
    longint r;
    r = atan_first_quad(labs(n), labs(d));
    if (d < 0) r = (180 << ANGLE_FRAC_BITS) - r;
    return n < 0 ? -r : r;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic longint scaled_axis(longint v);
    longint m;
    m = labs(v) * 312 / 10;
    return v < 0 ? -m : m;
  endfunction

  function automatic angles_t predict_angles(sample_t s);
    angles_t r;
    longint x, y, z, a [3];
    logic bad;
    bad = 1'b0;
    if (s.kind == REQ_ACCEL) begin
      x = longint'(signed'({s.b[1], s.b[0]}));
      y = longint'(signed'({s.b[3], s.b[2]}));
      z = longint'(signed'({s.b[5], s.b[4]}));
      a[0] = tilt_angle(x * 65536, magnitude(y, z), bad);
      a[1] = tilt_angle(y * 65536, magnitude(x, z), bad);
      a[2] = tilt_angle(magnitude(x, y), z * 65536, bad);
      r.val[0] = 21'(scaled_axis(x));
      r.val[1] = 21'(scaled_axis(y));
      r.val[2] = 21'(scaled_axis(z));
    end else begin
      x = longint'(signed'({s.b[0], s.b[1]}));
      z = longint'(signed'({s.b[2], s.b[3]}));
      y = longint'(signed'({s.b[4], s.b[5]}));
      a[0] = heading_angle(y * 65536, x * 65536);
      a[1] = heading_angle(z * 65536, x * 65536);
      a[2] = heading_angle(z * 65536, y * 65536);
      r.val[0] = 21'(x);
      r.val[1] = 21'(y);
      r.val[2] = 21'(z);
    end
    for (int i = 0; i < 3; i++) r.ang[i] = clamp16(a[i]);
    r.inv = bad;
    return r;
  endfunction

  function automatic sample_t make_sample(logic k, int ax, int ay, int az);
    sample_t s;
    s.kind = k;
    if (k == REQ_ACCEL) begin
      {s.b[1], s.b[0]} = ax[15:0];
      {s.b[3], s.b[2]} = ay[15:0];
      {s.b[5], s.b[4]} = az[15:0];
    end else begin
      {s.b[0], s.b[1]} = ax[15:0];
      {s.b[4], s.b[5]} = ay[15:0];
      {s.b[2], s.b[3]} = az[15:0];
    end
    return s;
  endfunction

  function automatic int pick_axis();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32767;
      2: return -32768;
      3: return $urandom_range(0, 20) - 10;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  // stimulus: directed corners first, then random samples
  initial begin
    int e [6] = '{0, 1, -1, 32767, -32768, 300};
    for (int k = 0; k < 2; k++) begin
      pending_q.push_back(make_sample(1'(k), 0, 0, 0));
      pending_q.push_back(make_sample(1'(k), 32767, 32767, 32767));
      pending_q.push_back(make_sample(1'(k), -32768, -32768, -32768));
      pending_q.push_back(make_sample(1'(k), -32768, 0, 0));
      pending_q.push_back(make_sample(1'(k), 0, 0, -5));
      pending_q.push_back(make_sample(1'(k), 0, 7, 0));
      pending_q.push_back(make_sample(1'(k), 0, -7, 3));
      pending_q.push_back(make_sample(1'(k), -100, 0, 50));
      pending_q.push_back(make_sample(1'(k), 32767, -32768, 1));
      pending_q.push_back(make_sample(1'(k), e[$urandom_range(0, 5)], -1, 1));
    end
    for (int n = 0; n < 950; n++)
      pending_q.push_back(make_sample(1'($urandom_range(0, 1)), pick_axis(), pick_axis(),
                                      pick_axis()));
  end

  // driver: bursts with random gaps
  always @(posedge clk) begin
    sample_t s;
    cycles <= cycles + 1;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_q.push_back(predict_angles(pending_q.pop_front()));
      if (start && busy) begin
        // hold the current transfer
      end else if (pending_q.size() == 0) begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else begin
        s = pending_q[0];
        start <= 1'b1;
        req_type <= s.kind;
        byte_0 <= s.b[0]; byte_1 <= s.b[1]; byte_2 <= s.b[2];
        byte_3 <= s.b[3]; byte_4 <= s.b[4]; byte_5 <= s.b[5];
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // monitor: compare each transfer out with the oldest prediction
  always @(posedge clk) begin
    angles_t w;
    logic signed [15:0] ga [3];
    logic signed [20:0] gv [3];
    if (!rst && done) begin
      ga = '{angle_first, angle_second, angle_third};
      gv = '{value_x, value_y, value_z};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result, expected none, actual angle %0d", $time, angle_first);
        errors++;
      end else begin
        w = expected_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (ga[i] !== w.ang[i]) begin
            $display("%0t angle %0d expected %0d actual %0d", $time, i, w.ang[i], ga[i]);
            errors++;
          end
          if (gv[i] !== w.val[i]) begin
            $display("%0t value %0d expected %0d actual %0d", $time, i, w.val[i], gv[i]);
            errors++;
          end
        end
        if (invalid !== w.inv) begin
          $display("%0t invalid expected %0b actual %0b", $time, w.inv, invalid);
          errors++;
        end
      end
    end
  end

  // reset, end of run and timeout
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (!(stim_done && expected_q.size() == 0) && cycles < CYCLE_LIMIT) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
    end else if (errors == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tha_pkg.sv
hw/rtl/tha_sqrt_cell.sv
hw/rtl/tha_cordic_cell.sv
hw/rtl/tilt_and_heading_angles.sv
hw/rtl/tha_checker.sv
tb/tb_tilt_and_heading_angles.sv
